FILE: rtl/core/sha256_pkg.sv
// ---------------------------------------------------------------------------
// sha-256 package
// shared types, constants and round functions for the message hasher
// ---------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WordWidth   = 32;
    localparam int unsigned ChainDepth  = 8;
    localparam int unsigned BlockWords  = 16;
    localparam int unsigned RoundCount  = 64;
    localparam int unsigned LenBits     = 64;
    localparam int unsigned WordIdxBits = $clog2(BlockWords);
    localparam int unsigned RoundBits   = $clog2(RoundCount);
    localparam int unsigned ChainBits   = $clog2(ChainDepth);
    localparam int unsigned LenWordLo   = 15;
    localparam int unsigned LenWordHi   = 14;
    localparam logic [7:0]  PadByte     = 8'h80;

    typedef logic [WordWidth-1:0] t_word;

    // datapath commands from the controller
    typedef struct packed {
        logic add_byte;     // place a message byte into the block buffer
        logic pad_byte;     // place the 0x80 marker at the fill position
        logic clr_word;     // clear buffer word at clr_idx
        logic [WordIdxBits-1:0] clr_idx;
        logic put_len;      // write the bit length into words 14 and 15
        logic load_work;    // copy chain words into working words, round 0
        logic round;        // run one compression round
        logic fold;         // add working words into chain words
        logic restart;      // chain to initial values, clear length and fill
        logic shift_out;    // rotate chain words for digest output
    } t_cmd;

    typedef struct packed {
        logic [WordIdxBits+1:0] fill;   // byte count in the block, 0..63
        logic [RoundBits-1:0]   round_idx;
        t_word                  head_word;
    } t_status;

    localparam t_word RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitH [ChainDepth] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/core/sha256_if.sv
// ---------------------------------------------------------------------------
// sha-256 stream interfaces
// valid/ready channels for message bytes and digest words
// ---------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;

    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, hash_word, word_index, last_word, input ready);
    modport sink   (input valid, hash_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha256_datapath.sv
// ---------------------------------------------------------------------------
// sha-256 datapath
// block buffer as rolling schedule, working words, chain words, bit length
// ---------------------------------------------------------------------------
module sha256_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [7:0]          i_byte,
    output sha256_pkg::t_status o_status
);

    localparam int unsigned Nw = sha256_pkg::BlockWords;
    localparam int unsigned Nc = sha256_pkg::ChainDepth;
    localparam int unsigned Fb = sha256_pkg::WordIdxBits + 2;

    sha256_pkg::t_word r_w [Nw];
    sha256_pkg::t_word n_w [Nw];
    sha256_pkg::t_word r_v [Nc];
    sha256_pkg::t_word n_v [Nc];
    sha256_pkg::t_word r_h [Nc];
    sha256_pkg::t_word n_h [Nc];
    logic [Fb-1:0]                      r_fill, n_fill;
    logic [sha256_pkg::LenBits-1:0]     r_len, n_len;
    logic [sha256_pkg::RoundBits-1:0]   r_rnd, n_rnd;

    sha256_pkg::t_word w_new, t1, t2, wr_word;
    logic [7:0]        wr_byte;
    logic [sha256_pkg::WordIdxBits-1:0] wr_idx;
    logic [1:0]        wr_lane;

    always_comb begin
        w_new = sha256_pkg::small_sigma1(r_w[14]) + r_w[9]
              + sha256_pkg::small_sigma0(r_w[1]) + r_w[0];
        t1 = r_v[7] + sha256_pkg::big_sigma1(r_v[4])
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha256_pkg::RoundK[r_rnd] + r_w[0];
        t2 = sha256_pkg::big_sigma0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        wr_byte = i_cmd.pad_byte ? sha256_pkg::PadByte : i_byte;
        wr_idx  = r_fill[Fb-1:2];
        wr_lane = r_fill[1:0];
        wr_word = r_w[wr_idx];
        unique case (wr_lane)
            2'd0: wr_word[31:24] = wr_byte;
            2'd1: wr_word[23:16] = wr_byte;
            2'd2: wr_word[15:8]  = wr_byte;
            default: wr_word[7:0] = wr_byte;
        endcase
        if (i_cmd.pad_byte) begin
            unique case (wr_lane)
                2'd0: wr_word[23:0] = '0;
                2'd1: wr_word[15:0] = '0;
                2'd2: wr_word[7:0]  = '0;
                default: wr_word = wr_word;
            endcase
        end

        n_w = r_w;
        n_v = r_v;
        n_h = r_h;
        n_fill = r_fill;
        n_len = r_len;
        n_rnd = r_rnd;
        if (i_cmd.add_byte || i_cmd.pad_byte) begin
            n_w[wr_idx] = wr_word;
            n_fill = r_fill + 1'b1;
        end
        if (i_cmd.add_byte) begin
            n_len = r_len + 64'd8;
        end
        if (i_cmd.clr_word) begin
            n_w[i_cmd.clr_idx] = '0;
        end
        if (i_cmd.put_len) begin
            n_w[sha256_pkg::LenWordHi] = r_len[63:32];
            n_w[sha256_pkg::LenWordLo] = r_len[31:0];
        end
        if (i_cmd.load_work) begin
            n_v = r_h;
            n_rnd = '0;
        end
        if (i_cmd.round) begin
            for (int i = 0; i < Nw - 1; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[Nw-1] = w_new;
            for (int i = Nc - 1; i > 0; i--) begin
                n_v[i] = r_v[i-1];
            end
            n_v[4] = r_v[3] + t1;
            n_v[0] = t1 + t2;
            n_rnd = r_rnd + 1'b1;
        end
        if (i_cmd.fold) begin
            for (int i = 0; i < Nc; i++) begin
                n_h[i] = r_h[i] + r_v[i];
            end
        end
        if (i_cmd.shift_out) begin
            for (int i = 0; i < Nc - 1; i++) begin
                n_h[i] = r_h[i+1];
            end
            n_h[Nc-1] = r_h[0];
        end
        if (i_cmd.restart) begin
            n_h = sha256_pkg::InitH;
            n_len = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= sha256_pkg::InitH;
            r_len <= '0;
            r_fill <= '0;
            r_rnd <= '0;
        end else begin
            r_h <= n_h;
            r_len <= n_len;
            r_fill <= n_fill;
            r_rnd <= n_rnd;
        end
        r_w <= n_w;
        r_v <= n_v;
    end

    assign o_status.fill      = r_fill;
    assign o_status.round_idx = r_rnd;
    assign o_status.head_word = r_h[0];

`ifndef NO_ASSERTIONS
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_byte && !i_cmd.restart |=> r_len == $past(r_len) + 64'd8)
        else $error("length did not advance");
    a_fill_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_byte && !i_cmd.restart |=> r_len[8:3] == r_fill)
        else $error("fill out of step with length");
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_work |=> r_rnd == '0)
        else $error("round counter not cleared");
`endif

endmodule

FILE: rtl/core/sha256_ctrl.sv
// ---------------------------------------------------------------------------
// sha-256 controller
// sequences byte intake, padding, compression and digest output
// ---------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha256_in_if.sink           in_ch,
    sha256_out_if.source        out_ch,
    input  sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PAD   = 8'b0000_0010,
        S_CLEAR = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_ROUND = 8'b0001_0000,
        S_FOLD  = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_PREP  = 8'b1000_0000
    } t_state;

    localparam int unsigned Ib = sha256_pkg::WordIdxBits;
    localparam int unsigned Cb = sha256_pkg::ChainBits;

    t_state r_state, n_state;
    logic   r_final, n_final;       // message closed, padding under way
    logic   r_lenin, n_lenin;       // last block carries the length
    logic   r_endq, n_endq;         // message end waits for a full-block compression
    logic [Ib-1:0] r_cidx, n_cidx;
    logic [Cb-1:0] r_oidx, n_oidx;
    logic   accept;

    assign in_ch.ready = (r_state == S_IDLE);
    assign accept = in_ch.valid && in_ch.ready;

    assign out_ch.valid      = (r_state == S_OUT);
    assign out_ch.hash_word  = i_status.head_word;
    assign out_ch.word_index = r_oidx;
    assign out_ch.last_word  = (r_oidx == Cb'(sha256_pkg::ChainDepth - 1));

    always_comb begin
        o_cmd = '0;
        o_cmd.clr_idx = r_cidx;
        n_state = r_state;
        n_final = r_final;
        n_lenin = r_lenin;
        n_endq = r_endq;
        n_cidx = r_cidx;
        n_oidx = r_oidx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.add_byte = in_ch.byte_present;
                    if (in_ch.byte_present && i_status.fill == '1) begin
                        n_state = S_LOAD;
                        n_lenin = 1'b0;
                        n_endq = in_ch.message_end;
                    end else if (in_ch.message_end) begin
                        n_final = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_byte = 1'b1;
                n_final = 1'b1;
                n_endq = 1'b0;
                n_cidx = Ib'(i_status.fill[Ib+1:2] + 1'b1);
                n_lenin = (i_status.fill < 6'd56);
                n_state = (i_status.fill[Ib+1:2] == '1) ? S_LOAD : S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.clr_word = 1'b1;
                n_cidx = r_cidx + 1'b1;
                if (r_cidx == '1) begin
                    o_cmd.put_len = r_lenin;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_idx == '1) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_oidx = '0;
                if (!r_final) begin
                    n_state = r_endq ? S_PAD : S_IDLE;
                end else if (r_lenin) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // second padding block: all zero except the length
                n_lenin = 1'b1;
                n_cidx = '0;
                n_state = S_CLEAR;
            end
            S_OUT: begin
                if (out_ch.ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_oidx = r_oidx + 1'b1;
                    if (out_ch.last_word) begin
                        o_cmd.restart = 1'b1;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
            r_lenin <= 1'b0;
            r_endq <= 1'b0;
            r_cidx <= '0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_lenin <= n_lenin;
            r_endq <= n_endq;
            r_cidx <= n_cidx;
            r_oidx <= n_oidx;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r_oidx))
        else $error("digest transfer dropped");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FOLD |-> $past(r_state) == S_ROUND)
        else $error("fold without rounds");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !in_ch.ready)
        else $error("input taken while busy");
    a_out_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> r_final)
        else $error("digest without message end");
`endif

endmodule

FILE: rtl/core/sha256_message_hasher.sv
// ---------------------------------------------------------------------------
// sha-256 message hasher
// byte-stream sha-256 with padding and digest output
// ---------------------------------------------------------------------------
// Takes one byte per transfer, marked present and optionally ending the message.
// A byte that completes a 64-byte block starts the compression (load, 64 rounds
// at one round per cycle, fold), during which no input is taken. On message end
// the block pads, runs one or two compressions (the second after clearing a block
// that then holds only the length), then offers the eight digest words, index 0
// first, one per cycle while the sink is ready, and returns to initial state.
// ---------------------------------------------------------------------------
module sha256_message_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha256_in_if.sink     in_ch,
    sha256_out_if.source  out_ch
);

    sha256_pkg::t_cmd    cmd;
    sha256_pkg::t_status status;

    sha256_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sha256_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (in_ch.data_byte),
        .o_status (status)
    );

endmodule
